/* hw/rtl/rde_pkg.sv */
// Shared constants and types for the radix digit encoder.
package rde_pkg;

  localparam int VALUE_W   = 64;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int RADIX_W   = 5;
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int CNT_W     = 7;
  localparam int NUM_BANKS = 2;
  localparam int BANK_CNT_W = 2;

  localparam int MAX_DIGITS_DEF = 64;
  localparam int MAX_RADIX      = 16;
  localparam int MIN_RADIX      = 2;

  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 64;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RESET_RADIX      = 5'd10;
  localparam logic [VALUE_W-1:0] RESET_ALPHA_LOW  = 64'h3736353433323130;
  localparam logic [VALUE_W-1:0] RESET_ALPHA_HIGH = 64'h4645444342413938;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             bank;
  } job_t;

endpackage

/* hw/rtl/radix_digit_encoder.sv */
// Top level of the radix digit encoder: configuration registers and block wiring.
// Each transaction on the input carries a 64-bit unsigned value; the block returns
// its digits in the configured radix (2..16) as alphabet characters, most
// significant first, with out_last_digit set on the final one. Each digit takes
// one 64-bit pass through the front end's division unit (eight quotient bits per
// cycle), so radix 2 takes up to 64 passes. The emitter reads the digit RAM in
// reverse, one read at a time, and runs while the front end converts the next
// value into the other RAM bank.
module radix_digit_encoder import rde_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int RAM_AW = $clog2(MAX_DIGITS) + 1;

  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [VALUE_W-1:0] alpha_low_r, alpha_low_nxt;
  logic [VALUE_W-1:0] alpha_high_r, alpha_high_nxt;
  logic [RADIX_W-1:0] eff_radix;
  logic [REG_IDX_W-1:0] reg_idx;
  logic               cfg_wr;

  logic               ram_we, ram_re;
  logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
  logic [DIGIT_W-1:0] ram_wdata, ram_rdata;
  logic               job_push, job_pop, job_valid;
  job_t               job_in, job_head;
  logic               bank_release;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    radix_nxt      = radix_r;
    alpha_low_nxt  = alpha_low_r;
    alpha_high_nxt = alpha_high_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_RADIX:      radix_nxt      = pwdata[RADIX_W-1:0];
        REG_ALPHA_LOW:  alpha_low_nxt  = pwdata;
        REG_ALPHA_HIGH: alpha_high_nxt = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIX:      prdata = PDATA_W'(radix_r);
      REG_ALPHA_LOW:  prdata = alpha_low_r;
      REG_ALPHA_HIGH: prdata = alpha_high_r;
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (radix_r < RADIX_W'(MIN_RADIX)) begin
      eff_radix = RADIX_W'(MIN_RADIX);
    end else if (radix_r > RADIX_W'(MAX_RADIX)) begin
      eff_radix = RADIX_W'(MAX_RADIX);
    end else begin
      eff_radix = radix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= RESET_RADIX;
      alpha_low_r  <= RESET_ALPHA_LOW;
      alpha_high_r <= RESET_ALPHA_HIGH;
    end else begin
      radix_r      <= radix_nxt;
      alpha_low_r  <= alpha_low_nxt;
      alpha_high_r <= alpha_high_nxt;
    end
  end

  rde_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .eff_radix    (eff_radix),
    .bank_release (bank_release),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .job_push     (job_push),
    .job_data     (job_in)
  );

  rde_ram #(.WIDTH(DIGIT_W), .DEPTH(1 << RAM_AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .not_empty (job_valid),
    .head      (job_head)
  );

  rde_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job_valid),
    .job            (job_head),
    .job_pop        (job_pop),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .bank_release   (bank_release),
    .alpha_low      (alpha_low_r),
    .alpha_high     (alpha_high_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

/* hw/rtl/rde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/rde_front.sv */
// Front end: accepts values and runs the iterative division, writing digits to RAM.
module rde_front import rde_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [VALUE_W-1:0]                  in_value,
  input  logic [RADIX_W-1:0]                  eff_radix,
  input  logic                                bank_release,
  output logic                                ram_we,
  output logic [$clog2(MAX_DIGITS):0]         ram_waddr,
  output logic [DIGIT_W-1:0]                  ram_wdata,
  output logic                                job_push,
  output job_t                                job_data
);

  localparam int IDX_W = $clog2(MAX_DIGITS);

  logic                  busy_r, busy_nxt;
  logic [VALUE_W-1:0]    quo_r, quo_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  bank_r, bank_nxt;
  logic                  nz_r, nz_nxt;
  logic [RADIX_W-1:0]    rad_r, rad_nxt;
  logic [BANK_CNT_W-1:0] banks_r, banks_nxt;

  logic [DIGIT_W-1:0]    div_rem;
  logic [DIV_BITS-1:0]   div_q;
  logic                  accept;
  logic                  last_step;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  conv_done;

  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [RADIX_W-1:0] t;
    r = rem_r;
    div_q = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, quo_r[VALUE_W-1-i]};
      if (t >= rad_r) begin
        t = t - rad_r;
        div_q[DIV_BITS-1-i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    div_rem = r;
  end

  assign in_stall  = busy_r || (banks_r == BANK_CNT_W'(NUM_BANKS));
  assign accept    = in_valid && !in_stall;
  assign last_step = busy_r && (step_r == STEP_W'(DIV_STEPS - 1));
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign conv_done = last_step && (!(nz_r || (|div_q)) || (cnt_inc == CNT_W'(MAX_DIGITS)));

  assign ram_we    = last_step;
  assign ram_waddr = {bank_r, cnt_r[IDX_W-1:0]};
  assign ram_wdata = div_rem;
  assign job_push  = conv_done;
  assign job_data  = '{cnt: cnt_inc, bank: bank_r};

  always_comb begin
    busy_nxt  = busy_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    bank_nxt  = bank_r;
    nz_nxt    = nz_r;
    rad_nxt   = rad_r;
    banks_nxt = banks_r + BANK_CNT_W'(accept) - BANK_CNT_W'(bank_release);
    if (accept) begin
      busy_nxt = 1'b1;
      quo_nxt  = in_value;
      rem_nxt  = '0;
      step_nxt = '0;
      cnt_nxt  = '0;
      nz_nxt   = 1'b0;
      rad_nxt  = eff_radix;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[VALUE_W-DIV_BITS-1:0], div_q};
      rem_nxt  = div_rem;
      step_nxt = step_r + STEP_W'(1);
      nz_nxt   = nz_r || (|div_q);
      if (last_step) begin
        rem_nxt = '0;
        nz_nxt  = 1'b0;
        cnt_nxt = cnt_inc;
        if (conv_done) begin
          busy_nxt = 1'b0;
          bank_nxt = !bank_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      bank_r  <= 1'b0;
      banks_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      bank_r  <= bank_nxt;
      banks_r <= banks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    cnt_r  <= cnt_nxt;
    nz_r   <= nz_nxt;
    rad_r  <= rad_nxt;
  end

  a_banks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    banks_r <= BANK_CNT_W'(NUM_BANKS))
    else $error("more RAM banks in use than exist");

endmodule

/* hw/rtl/rde_queue.sv */
// Two-entry job queue between the division front end and the emitter.
module rde_queue import rde_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != 2'd2 || pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("job queue underflow");

endmodule

/* hw/rtl/rde_back.sv */
// Back end: reads digits out of RAM in reverse and drives the character stream.
module rde_back import rde_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  job_t                          job,
  output logic                          job_pop,
  output logic                          ram_re,
  output logic [$clog2(MAX_DIGITS):0]   ram_raddr,
  input  logic [DIGIT_W-1:0]            ram_rdata,
  output logic                          bank_release,
  input  logic [VALUE_W-1:0]            alpha_low,
  input  logic [VALUE_W-1:0]            alpha_high,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CHAR_W-1:0]             out_digit_char,
  output logic                          out_last_digit
);

  localparam int IDX_W = $clog2(MAX_DIGITS);

  logic              active_r, active_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              bank_r, bank_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_acc;
  logic              issue;
  logic              idx_zero;
  logic [CNT_W-1:0]  job_top;
  logic [VALUE_W-1:0] alpha_word;

  assign out_acc   = out_valid_r && !out_stall;
  assign issue     = active_r && !pend_r && (!out_valid_r || out_acc);
  assign idx_zero  = (idx_r == '0);
  assign job_pop   = !active_r && job_valid;
  assign job_top   = job.cnt - CNT_W'(1);

  assign ram_re       = issue;
  assign ram_raddr    = {bank_r, idx_r};
  assign bank_release = issue && idx_zero;

  assign alpha_word = ram_rdata[DIGIT_W-1] ? alpha_high : alpha_low;

  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    bank_nxt      = bank_r;
    pend_nxt      = issue;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (job_pop) begin
      active_nxt = 1'b1;
      idx_nxt    = job_top[IDX_W-1:0];
      bank_nxt   = job.bank;
    end else if (issue) begin
      pend_last_nxt = idx_zero;
      if (idx_zero) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - IDX_W'(1);
      end
    end
    if (pend_r) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = alpha_word[{ram_rdata[DIGIT_W-2:0], 3'b000} +: CHAR_W];
      out_last_nxt  = pend_last_r;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    bank_r      <= bank_nxt;
    pend_last_r <= pend_last_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

  a_pend_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (!out_valid_r || !out_stall))
    else $error("read data arrives while output register is held");

endmodule

/* bench/radix_digit_checker.sv */
// Checker for the radix digit encoder: tracks the registers, predicts each character, compares.
module radix_digit_checker import rde_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [CHAR_W-1:0]  out_digit_char,
  input  logic               out_last_digit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  logic [RADIX_W-1:0] radix_q;
  logic [VALUE_W-1:0] alpha_lo_q;
  logic [VALUE_W-1:0] alpha_hi_q;
  char_beat_t         expected_chars[$];
  int                 errs;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    return d[DIGIT_W-1] ? alpha_hi_q[d[DIGIT_W-2:0]*CHAR_W +: CHAR_W]
                        : alpha_lo_q[d[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
  endfunction

  task automatic report(input string what, input string detail);
    errs++;
    if (errs <= REPORT_LIMIT) begin
      $display("%0t ns: %s mismatch: %s", $time, what, detail);
    end
  endtask

  // digits come out least significant first, then get queued in reverse
  task automatic queue_digits(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] q;
    logic [DIGIT_W-1:0] digs[MAX_DIGITS];
    char_beat_t         beat;
    int                 n;
    base = VALUE_W'(radix_q);
    if (base < MIN_RADIX) base = VALUE_W'(MIN_RADIX);
    if (base > MAX_RADIX) base = VALUE_W'(MAX_RADIX);
    q = value;
    n = 0;
    do begin
      if (n < MAX_DIGITS) begin
        digs[n] = DIGIT_W'(q % base);
        n++;
      end
      q = q / base;
    end while (q != 0);
    for (int k = n - 1; k >= 0; k--) begin
      beat.ch   = glyph(digs[k]);
      beat.last = (k == 0);
      expected_chars.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    logic [REG_IDX_W-1:0] idx;
    logic [PDATA_W-1:0]   want;
    bit                   known;
    char_beat_t           head;
    if (!rst_n) begin
      radix_q    = RESET_RADIX;
      alpha_lo_q = RESET_ALPHA_LOW;
      alpha_hi_q = RESET_ALPHA_HIGH;
      errs       = 0;
      expected_chars.delete();
    end else begin
      if (psel && penable && pready) begin
        idx = paddr[PADDR_W-1:3];
        if (pwrite) begin
          case (idx)
            REG_RADIX:      radix_q = pwdata[RADIX_W-1:0];
            REG_ALPHA_LOW:  alpha_lo_q = pwdata;
            REG_ALPHA_HIGH: alpha_hi_q = pwdata;
            default: ;
          endcase
        end else begin
          known = 1'b1;
          want  = '0;
          case (idx)
            REG_RADIX:      want = PDATA_W'(radix_q);
            REG_ALPHA_LOW:  want = alpha_lo_q;
            REG_ALPHA_HIGH: want = alpha_hi_q;
            default:        known = 1'b0;
          endcase
          if (known && prdata !== want) begin
            report("register read", $sformatf("index %0d expected %h, got %h", idx, want, prdata));
          end
        end
      end
      if (in_valid && !in_stall) queue_digits(in_value);
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report("output", $sformatf("no transaction pending, got char %02h last %0b",
                                     out_digit_char, out_last_digit));
        end else begin
          head = expected_chars.pop_front();
          if (out_digit_char !== head.ch || out_last_digit !== head.last) begin
            report("output", $sformatf("expected char %02h last %0b, got char %02h last %0b",
                                       head.ch, head.last, out_digit_char, out_last_digit));
          end
        end
      end
    end
    mismatches  <= errs;
    outstanding <= expected_chars.size();
  end

endmodule

/* bench/tb_radix_digit_encoder.sv */
// Testbench top for the radix digit encoder: clock, reset, stimulus, stalls and verdict.
module tb_radix_digit_encoder;
  import rde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_PCT        = 37;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 25;
  localparam int CALM_PHASE      = 3;

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_stall = 1'b0;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic               in_stall;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_digit_char;
  logic               out_last_digit;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 mismatches;
  int                 outstanding;
  int                 tx_idle_pct = IDLE_PCT;
  int                 rx_idle_pct = IDLE_PCT;
  logic               hold_off_go = 1'b0;

  radix_digit_encoder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digit_char(out_digit_char), .out_last_digit(out_last_digit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  radix_digit_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digit_char(out_digit_char), .out_last_digit(out_last_digit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic [VALUE_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // as many short numbers as wide ones, plus a few zeros and all-ones
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int                 sel;
    int                 len;
    sel = $urandom_range(0, 9);
    v   = random_word();
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    len = (sel < 6) ? $urandom_range(1, 24) : $urandom_range(25, VALUE_W);
    if (len < VALUE_W) v &= (64'd1 << len) - 64'd1;
    return v;
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] v);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // leaves psel high so accesses can run back to back
  task automatic apb_access(input logic write, input logic [REG_IDX_W-1:0] idx,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [PDATA_W-1:0] radix_word,
                           input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi);
    wait_idle();
    apb_access(1'b1, REG_RADIX, radix_word);
    apb_access(1'b1, REG_ALPHA_LOW, lo);
    apb_access(1'b1, REG_ALPHA_HIGH, hi);
    apb_access(1'b0, REG_RADIX, '0);
    apb_access(1'b0, REG_ALPHA_LOW, '0);
    apb_access(1'b0, REG_ALPHA_HIGH, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PDATA_W-1:0] radix_word;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset alphabet, decimal
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value('1);
    send_value(64'd10000000000000000000);

    // binary, junk above the radix field
    configure(64'hFFFF_FFFF_FFFF_FFE2, 64'h6867_6665_6463_6261, 64'h7877_7675_7473_7271);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'd0);
    send_value(64'd1);

    configure(64'd16, '1, '0);
    send_value(64'h0123_4567_89AB_CDEF);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
    send_value('1);

    // radix below range behaves as binary, above range as hex
    configure(64'd0, RESET_ALPHA_LOW, RESET_ALPHA_HIGH);
    send_value(64'd5);
    configure(64'd1, RESET_ALPHA_LOW, RESET_ALPHA_HIGH);
    send_value(64'd6);
    configure(64'd17, RESET_ALPHA_LOW, RESET_ALPHA_HIGH);
    send_value(64'd255);
    configure(64'd31, RESET_ALPHA_LOW, RESET_ALPHA_HIGH);
    send_value('1);

    // write to an unmapped index must leave the radix alone
    wait_idle();
    apb_access(1'b1, REG_UNUSED, 64'd3);
    apb_access(1'b0, REG_RADIX, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    send_value(64'd12345);

    // long output hold-off while the input keeps offering
    configure(64'd10, RESET_ALPHA_LOW, RESET_ALPHA_HIGH);
    tx_idle_pct = 0;
    hold_off_go <= 1'b1;
    repeat (12) send_value(64'($urandom_range(0, 99999)));
    tx_idle_pct = IDLE_PCT;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      radix_word = random_word();
      if (p == 0) radix_word[RADIX_W-1:0] = 5'd2;
      else if (p == 1) radix_word[RADIX_W-1:0] = 5'd16;
      else if ($urandom_range(0, 4) == 0) radix_word[RADIX_W-1:0] = RADIX_W'($urandom_range(0, 31));
      else radix_word[RADIX_W-1:0] = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
      configure(radix_word, random_word(), random_word());
      tx_idle_pct = (p == CALM_PHASE) ? 0 : IDLE_PCT;
      rx_idle_pct = (p == CALM_PHASE) ? 0 : IDLE_PCT;
      repeat (PHASE_ITEMS) send_value(random_value());
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
